// ===== sv/rafa_pkg.sv =====
// shared types, codes and defaults for the first-fit region allocator
`default_nettype none

package rafa_pkg;

    // default sizes
    localparam int MAX_IDS_DEF            = 1024;
    localparam int FREE_DEPTH_DEF         = 64;
    localparam int DATA_BLOCKS_DEF        = 65536;
    localparam int INDIRECT_BLOCKS_DEF    = 4096;
    localparam int VERTICES_PER_BLOCK_DEF = 16;
    localparam int INDICES_PER_BLOCK_DEF  = 24;

    // fixed field widths and the reset margin
    localparam int CAP_W  = 16;
    localparam int NEED_W = 17;
    localparam logic [3:0] MARGIN_RESET = 4'd2;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_UNKNOWN   = 3'd1,
        STAT_NO_IDS    = 3'd2,
        STAT_LIST_FULL = 3'd3,
        STAT_NO_SPACE  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_COMMIT,
        ST_TAKE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic        op;
        logic        has_id;
        logic [9:0]  owner_id;
        logic [12:0] block_count;
    } req_t;

    typedef struct packed {
        logic [9:0]  granted_id;
        logic [15:0] region_start;
        logic [15:0] region_capacity;
        logic [11:0] indirect_slot;
        logic [21:0] vertex_offset;
        logic [21:0] index_offset;
        logic        cleared_valid;
        logic [11:0] cleared_slot;
        logic [2:0]  status;
    } rsp_t;

    // free list control
    typedef struct packed {
        logic start;
        logic push;
        logic remove;
    } fl_ctrl_t;

    // free list search status
    typedef struct packed {
        logic done;
        logic hit;
    } fl_stat_t;

endpackage

`default_nettype wire

// ===== sv/rafa_cell.sv =====
// one free-list cell: holds a region, checks it against the search token
`default_nettype none

module rafa_cell #(
    parameter int RW  = 45,
    parameter int SLW = 12,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  rafa_pkg::fl_ctrl_t           ctrl,
    input  wire  [CW-1:0]                count,
    input  wire  [rafa_pkg::NEED_W-1:0]  need,
    input  wire  [RW-1:0]                push_data,
    input  wire  [RW-1:0]                up_data,
    input  wire                          token_in,
    output logic                         token_out,
    output logic                         hit,
    output logic                         miss,
    output logic [RW-1:0]                data
);

    logic          token_reg, token_next;
    logic          passed_reg, passed_next;
    logic [RW-1:0] data_reg, data_next;
    logic          valid;
    logic          fits;

    // occupancy and fit check
    assign valid = count > CW'(IDX);
    assign fits  = need < {1'b0, data_reg[SLW +: rafa_pkg::CAP_W]};

    assign hit       = token_reg & valid & fits;
    assign miss      = token_reg & ~valid;
    assign token_out = token_reg & valid & ~fits;
    assign data      = data_reg;

    // token and passed flag
    always_comb
    begin
        token_next  = token_in;
        passed_next = passed_reg;
        if (ctrl.start)
        begin
            passed_next = 1'b0;
        end
        else if (token_out)
        begin
            passed_next = 1'b1;
        end
    end

    // append at the fill point, shift down above a removed entry
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push && count == CW'(IDX))
        begin
            data_next = push_data;
        end
        else if (ctrl.remove && !passed_reg)
        begin
            data_next = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg  <= 1'b0;
            passed_reg <= 1'b0;
        end
        else
        begin
            token_reg  <= token_next;
            passed_reg <= passed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== sv/rafa_free_list.sv =====
// ordered free list built as a row of cells with a travelling search token
`default_nettype none

module rafa_free_list #(
    parameter int FREE_DEPTH = rafa_pkg::FREE_DEPTH_DEF,
    parameter int RW         = 45,
    parameter int SLW        = 12
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  rafa_pkg::fl_ctrl_t                  ctrl,
    input  wire  [rafa_pkg::NEED_W-1:0]         need,
    input  wire  [RW-1:0]                       push_data,
    output rafa_pkg::fl_stat_t                  stat,
    output logic [RW-1:0]                       hit_data,
    output logic [$clog2(FREE_DEPTH+1)-1:0]     count
);

    localparam int CW = $clog2(FREE_DEPTH+1);

    logic [CW-1:0]         count_reg, count_next;
    logic [FREE_DEPTH:0]   tok;
    logic [FREE_DEPTH-1:0] hit_vec;
    logic [FREE_DEPTH-1:0] miss_vec;
    logic [RW-1:0]         cell_data [FREE_DEPTH];

    assign tok[0] = ctrl.start;

    // row of cells
    for (genvar i = 0; i < FREE_DEPTH; i++)
    begin : g_cell
        logic [RW-1:0] up;
        if (i == FREE_DEPTH-1)
        begin : g_last
            assign up = '0;
        end
        else
        begin : g_mid
            assign up = cell_data[i+1];
        end

        rafa_cell #(
            .RW  (RW),
            .SLW (SLW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .need      (need),
            .push_data (push_data),
            .up_data   (up),
            .token_in  (tok[i]),
            .token_out (tok[i+1]),
            .hit       (hit_vec[i]),
            .miss      (miss_vec[i]),
            .data      (cell_data[i])
        );
    end

    // search outcome
    assign stat.hit  = |hit_vec;
    assign stat.done = (|hit_vec) | (|miss_vec) | tok[FREE_DEPTH];

    // pick the data of the one cell that hit
    always_comb
    begin
        hit_data = '0;
        for (int i = 0; i < FREE_DEPTH; i++)
        begin
            if (hit_vec[i])
            begin
                hit_data = hit_data | cell_data[i];
            end
        end
    end

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

// ===== sv/region_allocator_first_fit.sv =====
// top level of the first-fit region allocator
`default_nettype none

// Allocates, resizes and frees data regions for owner ids. Each request
// transaction gives exactly one response transaction. After reset the
// owner table is swept clear, one entry a cycle, and no request is taken
// meanwhile (margin writes are taken). A request that needs no search
// (free, error, or a resize that fits) goes from decide to result; else
// the search token walks the free-list cells one per cycle until the
// first region that fits, and the commit and take states then update the
// tables; a search that ends in out of space skips commit and take.
// A response waits in its own register, so a new request can enter while
// it is still stalled.
module region_allocator_first_fit #(
    parameter int MAX_IDS            = rafa_pkg::MAX_IDS_DEF,
    parameter int FREE_DEPTH         = rafa_pkg::FREE_DEPTH_DEF,
    parameter int DATA_BLOCKS        = rafa_pkg::DATA_BLOCKS_DEF,
    parameter int INDIRECT_BLOCKS    = rafa_pkg::INDIRECT_BLOCKS_DEF,
    parameter int VERTICES_PER_BLOCK = rafa_pkg::VERTICES_PER_BLOCK_DEF,
    parameter int INDICES_PER_BLOCK  = rafa_pkg::INDICES_PER_BLOCK_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_stall,
    input  rafa_pkg::req_t       req,
    output logic                 rsp_valid,
    input  wire                  rsp_stall,
    output rafa_pkg::rsp_t       rsp,
    input  wire                  cfg_wr_en,
    input  wire  [3:0]           cfg_wr_data
);

    localparam int IDW = $clog2(MAX_IDS);
    localparam int SW  = $clog2(DATA_BLOCKS) + 1;
    localparam int SLW = $clog2(INDIRECT_BLOCKS);
    localparam int CPW = rafa_pkg::CAP_W;
    localparam int RW  = SW + CPW + SLW;
    localparam int CW  = $clog2(FREE_DEPTH+1);
    localparam int NW  = rafa_pkg::NEED_W;
    localparam int PW  = SW + 7;

    rafa_pkg::state_t  state_reg, state_next;
    rafa_pkg::status_t status_reg;
    rafa_pkg::status_t dec_status;

    logic [3:0]     margin_reg;
    logic           op_reg, has_id_reg;
    logic [9:0]     oid_reg;
    logic [12:0]    blocks_reg;
    logic [NW-1:0]  need_reg;
    logic [RW:0]    owner_rd_reg;
    logic [IDW-1:0] fifo_rd_reg;
    logic [IDW-1:0] fifo_head_reg;
    logic [IDW:0]   fifo_cnt_reg;
    logic [IDW:0]   id_cnt_reg;
    logic [SW-1:0]  data_top_reg;
    logic [SLW:0]   ind_top_reg;
    logic [IDW-1:0] clr_idx_reg;
    logic           hit_reg, extra_reg, bump_reg;
    logic [RW-1:0]  region_reg;
    logic           has_region_reg;
    logic [IDW-1:0] res_id_reg;
    logic           res_clr_reg;
    logic [SLW-1:0] res_cslot_reg;
    logic           rsp_valid_reg;
    rafa_pkg::rsp_t rsp_reg, rsp_next;

    // memories
    logic [RW:0]    owner_mem [MAX_IDS];
    logic [IDW-1:0] fifo_mem  [MAX_IDS];

    // strobes
    logic               accept;
    logic               load_rsp;
    logic               own_we;
    logic [IDW-1:0]     own_waddr;
    logic [RW:0]        own_wdata;
    logic               fifo_we;
    logic [IDW-1:0]     fifo_waddr;
    rafa_pkg::fl_ctrl_t fl_ctrl;
    logic [RW-1:0]      fl_push_data;
    rafa_pkg::fl_stat_t fl_stat;
    logic [RW-1:0]      fl_hit_data;
    logic [CW-1:0]      fl_count;

    // decision terms
    logic [RW-1:0]  old;
    logic [CPW-1:0] old_cap;
    logic [SLW-1:0] old_slot;
    logic           known, fl_full, id_ok, upd_fit, dec_search;
    logic           extra_ok, bump_ok, srch_fail;
    logic           from_fifo;
    logic [IDW-1:0] nid;
    logic [IDW+1:0] tail_sum;
    logic [RW-1:0]  bump_region;

    assign old      = owner_rd_reg[RW-1:0];
    assign old_cap  = old[SLW +: CPW];
    assign old_slot = old[SLW-1:0];
    assign known    = (32'(oid_reg) < 32'(MAX_IDS)) && owner_rd_reg[RW];
    assign fl_full  = fl_count == CW'(FREE_DEPTH);
    assign id_ok    = (fifo_cnt_reg != '0) || (32'(id_cnt_reg) < 32'(MAX_IDS));
    assign upd_fit  = known && ({3'b000, blocks_reg} <= old_cap);

    assign dec_search = (op_reg == rafa_pkg::OP_ALLOC) &&
                        (has_id_reg ? (known && !upd_fit && !fl_full) : id_ok);

    assign extra_ok  = has_id_reg && (need_reg < {1'b0, old_cap});
    assign bump_ok   = !need_reg[NW-1] &&
                       (32'(data_top_reg) + 32'(need_reg) <= 32'(DATA_BLOCKS)) &&
                       (32'(ind_top_reg) < 32'(INDIRECT_BLOCKS));
    assign srch_fail = !fl_stat.hit && !extra_ok && !bump_ok;

    assign bump_region = {data_top_reg, need_reg[CPW-1:0], ind_top_reg[SLW-1:0]};

    assign from_fifo = fifo_cnt_reg != '0;
    assign nid       = has_id_reg ? IDW'(oid_reg) :
                       (from_fifo ? fifo_rd_reg : id_cnt_reg[IDW-1:0]);

    // fifo tail with wrap
    assign tail_sum   = (IDW+2)'(fifo_head_reg) + (IDW+2)'(fifo_cnt_reg);
    assign fifo_waddr = (32'(tail_sum) >= 32'(MAX_IDS)) ?
                        IDW'(32'(tail_sum) - 32'(MAX_IDS)) : IDW'(tail_sum);

    // status of the decide step
    always_comb
    begin
        dec_status = rafa_pkg::STAT_OK;
        if (op_reg == rafa_pkg::OP_FREE || has_id_reg)
        begin
            if (!known)
            begin
                dec_status = rafa_pkg::STAT_UNKNOWN;
            end
            else if (fl_full && (op_reg == rafa_pkg::OP_FREE || !upd_fit))
            begin
                dec_status = rafa_pkg::STAT_LIST_FULL;
            end
        end
        else if (!id_ok)
        begin
            dec_status = rafa_pkg::STAT_NO_IDS;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rafa_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == IDW'(MAX_IDS-1))
                begin
                    state_next = rafa_pkg::ST_IDLE;
                end
            end
            rafa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rafa_pkg::ST_DECIDE;
                end
            end
            rafa_pkg::ST_DECIDE:
            begin
                state_next = dec_search ? rafa_pkg::ST_SEARCH : rafa_pkg::ST_RESULT;
            end
            rafa_pkg::ST_SEARCH:
            begin
                if (fl_stat.done)
                begin
                    state_next = srch_fail ? rafa_pkg::ST_RESULT : rafa_pkg::ST_COMMIT;
                end
            end
            rafa_pkg::ST_COMMIT:
            begin
                state_next = rafa_pkg::ST_TAKE;
            end
            rafa_pkg::ST_TAKE:
            begin
                state_next = rafa_pkg::ST_RESULT;
            end
            rafa_pkg::ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = rafa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rafa_pkg::ST_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb
    begin
        accept       = 1'b0;
        load_rsp     = 1'b0;
        own_we       = 1'b0;
        own_waddr    = nid;
        own_wdata    = {1'b1, region_reg};
        fifo_we      = 1'b0;
        fl_ctrl      = '0;
        fl_push_data = old;
        unique case (state_reg)
            rafa_pkg::ST_CLEAR:
            begin
                own_we    = 1'b1;
                own_waddr = clr_idx_reg;
                own_wdata = '0;
            end
            rafa_pkg::ST_IDLE:
            begin
                accept = req_valid;
            end
            rafa_pkg::ST_DECIDE:
            begin
                fl_ctrl.start = dec_search;
                if (op_reg == rafa_pkg::OP_FREE && dec_status == rafa_pkg::STAT_OK)
                begin
                    fl_ctrl.push = 1'b1;
                    own_we       = 1'b1;
                    own_waddr    = IDW'(oid_reg);
                    own_wdata    = {1'b0, old};
                    fifo_we      = 32'(fifo_cnt_reg) < 32'(MAX_IDS);
                end
            end
            rafa_pkg::ST_SEARCH:
            begin
            end
            rafa_pkg::ST_COMMIT:
            begin
                fl_ctrl.push = has_id_reg && !extra_reg;
            end
            rafa_pkg::ST_TAKE:
            begin
                fl_ctrl.remove = hit_reg;
                own_we         = 1'b1;
            end
            rafa_pkg::ST_RESULT:
            begin
                load_rsp = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
            end
        endcase
    end

    assign req_stall = state_reg != rafa_pkg::ST_IDLE;

    rafa_free_list #(
        .FREE_DEPTH (FREE_DEPTH),
        .RW         (RW),
        .SLW        (SLW)
    ) u_free_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fl_ctrl),
        .need      (need_reg),
        .push_data (fl_push_data),
        .stat      (fl_stat),
        .hit_data  (fl_hit_data),
        .count     (fl_count)
    );

    // owner table and id fifo
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owner_mem[own_waddr] <= own_wdata;
        end
        if (accept)
        begin
            owner_rd_reg <= owner_mem[IDW'(req.owner_id)];
        end
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= IDW'(oid_reg);
        end
        if (accept)
        begin
            fifo_rd_reg <= fifo_mem[fifo_head_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rafa_pkg::ST_CLEAR;
            margin_reg    <= rafa_pkg::MARGIN_RESET;
            clr_idx_reg   <= '0;
            fifo_head_reg <= '0;
            fifo_cnt_reg  <= '0;
            id_cnt_reg    <= '0;
            data_top_reg  <= '0;
            ind_top_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                margin_reg <= cfg_wr_data;
            end
            if (state_reg == rafa_pkg::ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDW'(1);
            end
            // fifo push on free, pop or counter step on a new owner
            if (fifo_we)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + (IDW+1)'(1);
            end
            if (state_reg == rafa_pkg::ST_TAKE && !has_id_reg)
            begin
                if (from_fifo)
                begin
                    fifo_head_reg <= (fifo_head_reg == IDW'(MAX_IDS-1)) ?
                                     '0 : fifo_head_reg + IDW'(1);
                    fifo_cnt_reg  <= fifo_cnt_reg - (IDW+1)'(1);
                end
                else
                begin
                    id_cnt_reg <= id_cnt_reg + (IDW+1)'(1);
                end
            end
            // bump the tops
            if (state_reg == rafa_pkg::ST_TAKE && bump_reg)
            begin
                data_top_reg <= SW'(32'(data_top_reg) + 32'(need_reg));
                ind_top_reg  <= ind_top_reg + (SLW+1)'(1);
            end
            // response register
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.op;
            has_id_reg <= req.has_id;
            oid_reg    <= req.owner_id;
            blocks_reg <= req.block_count;
            need_reg   <= NW'(req.block_count) * NW'(margin_reg);
        end
        if (state_reg == rafa_pkg::ST_DECIDE)
        begin
            status_reg     <= dec_status;
            res_id_reg     <= IDW'(oid_reg);
            region_reg     <= old;
            has_region_reg <= (op_reg == rafa_pkg::OP_ALLOC) && upd_fit;
            // a new owner never releases a slot
            res_clr_reg    <= (op_reg == rafa_pkg::OP_FREE) || (has_id_reg && !upd_fit);
            res_cslot_reg  <= old_slot;
        end
        if (state_reg == rafa_pkg::ST_SEARCH && fl_stat.done)
        begin
            status_reg     <= srch_fail ? rafa_pkg::STAT_NO_SPACE : rafa_pkg::STAT_OK;
            hit_reg        <= fl_stat.hit;
            extra_reg      <= !fl_stat.hit && extra_ok;
            bump_reg       <= !fl_stat.hit && !extra_ok;
            has_region_reg <= 1'b1;
            if (fl_stat.hit)
            begin
                region_reg <= fl_hit_data;
            end
            else if (extra_ok)
            begin
                region_reg <= old;
            end
            else
            begin
                region_reg <= bump_region;
            end
        end
        if (state_reg == rafa_pkg::ST_TAKE)
        begin
            res_id_reg <= nid;
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // response fields, all zero but status on an error
    always_comb
    begin
        logic [SW-1:0] start;
        start    = region_reg[RW-1 -: SW];
        rsp_next = '0;
        rsp_next.status = status_reg;
        if (status_reg == rafa_pkg::STAT_OK)
        begin
            rsp_next.granted_id    = 10'(res_id_reg);
            rsp_next.cleared_valid = res_clr_reg;
            rsp_next.cleared_slot  = res_clr_reg ? 12'(res_cslot_reg) : 12'd0;
            if (has_region_reg)
            begin
                rsp_next.region_start    = 16'(start);
                rsp_next.region_capacity = region_reg[SLW +: CPW];
                rsp_next.indirect_slot   = 12'(region_reg[SLW-1:0]);
                rsp_next.vertex_offset   = 22'(PW'(start) * PW'(VERTICES_PER_BLOCK));
                rsp_next.index_offset    = 22'(PW'(start) * PW'(INDICES_PER_BLOCK));
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the first-fit region allocator: directed and random traffic with a predictor
`timescale 1ns / 1ps

module tb;

    localparam int NIDS     = rafa_pkg::MAX_IDS_DEF;
    localparam int NFREE    = rafa_pkg::FREE_DEPTH_DEF;
    localparam int NDATA    = rafa_pkg::DATA_BLOCKS_DEF;
    localparam int NIND     = rafa_pkg::INDIRECT_BLOCKS_DEF;
    localparam int VPB      = rafa_pkg::VERTICES_PER_BLOCK_DEF;
    localparam int IPB      = rafa_pkg::INDICES_PER_BLOCK_DEF;
    localparam int RUN_CAP  = 1500000;
    localparam int HOLD_LEN = 400;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    rafa_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    rafa_pkg::rsp_t rsp;
    logic           cfg_wr_en;
    logic [3:0]     cfg_wr_data;

    // traffic queues
    rafa_pkg::req_t pending_reqs[$];
    rafa_pkg::rsp_t expected_grants[$];

    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_go;
    logic hold_done;
    int   hold_cnt;
    int   cycle_cnt = 0;
    int   err_cnt = 0;

    // predictor state
    int unsigned margin;
    int unsigned id_ctr;
    int unsigned fifo_ids[NIDS];
    int unsigned fifo_head;
    int unsigned fifo_cnt;
    bit          own_v[NIDS];
    int unsigned own_start[NIDS];
    int unsigned own_cap[NIDS];
    int unsigned own_slot[NIDS];
    int unsigned fl_start[NFREE];
    int unsigned fl_cap[NFREE];
    int unsigned fl_slot[NFREE];
    int unsigned fl_cnt;
    int unsigned data_top;
    int unsigned ind_top;

    region_allocator_first_fit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // build one grant
    function automatic rafa_pkg::rsp_t make_grant(int unsigned id, int unsigned st,
                                                  int unsigned cap, int unsigned slot,
                                                  bit region, bit clr, int unsigned cslot,
                                                  rafa_pkg::status_t stat);
        rafa_pkg::rsp_t g;
        g = '0;
        g.status = stat;
        if (stat == rafa_pkg::STAT_OK)
        begin
            g.granted_id = id[9:0];
            if (region)
            begin
                g.region_start    = st[15:0];
                g.region_capacity = cap[15:0];
                g.indirect_slot   = slot[11:0];
                g.vertex_offset   = 22'(st * VPB);
                g.index_offset    = 22'(st * IPB);
            end
            g.cleared_valid = clr;
            g.cleared_slot  = clr ? cslot[11:0] : 12'd0;
        end
        return g;
    endfunction

    // first entry whose capacity exceeds need; an extra entry stands past the end
    function automatic int first_fit(int unsigned need, bit use_extra, int unsigned extra_cap);
        for (int i = 0; i < fl_cnt; i++)
        begin
            if (need < fl_cap[i])
                return i;
        end
        if (use_extra && need < extra_cap)
            return fl_cnt;
        return -1;
    endfunction

    function automatic bit bump_fits(int unsigned need);
        return need <= 65535 && data_top + need <= NDATA && ind_top < NIND;
    endfunction

    // take a free-list entry (or bump) into the owner's table slot
    function automatic void place_region(int unsigned id, int hit, int unsigned need);
        if (hit >= 0)
        begin
            own_start[id] = fl_start[hit];
            own_cap[id]   = fl_cap[hit];
            own_slot[id]  = fl_slot[hit];
            for (int i = hit; i + 1 < fl_cnt; i++)
            begin
                fl_start[i] = fl_start[i + 1];
                fl_cap[i]   = fl_cap[i + 1];
                fl_slot[i]  = fl_slot[i + 1];
            end
            fl_cnt--;
        end
        else
        begin
            own_start[id] = data_top;
            own_cap[id]   = need;
            own_slot[id]  = ind_top;
            data_top      += need;
            ind_top++;
        end
    endfunction

    function automatic void push_free(int unsigned st, int unsigned cap, int unsigned slot);
        fl_start[fl_cnt] = st;
        fl_cap[fl_cnt]   = cap;
        fl_slot[fl_cnt]  = slot;
        fl_cnt++;
    endfunction

    // predictor: advance the allocator state and give the grant it produces
    function automatic rafa_pkg::rsp_t predict_grant(rafa_pkg::req_t r);
        int unsigned id;
        int unsigned blocks;
        int unsigned need;
        int unsigned o_st;
        int unsigned o_cap;
        int unsigned o_slot;
        int          hit;
        bit          known;
        id     = r.owner_id;
        blocks = r.block_count;
        need   = blocks * margin;
        known  = own_v[id];
        if (r.op == rafa_pkg::OP_FREE)
        begin
            if (!known)
                return make_grant(0, 0, 0, 0, 0, 0, 0, rafa_pkg::STAT_UNKNOWN);
            if (fl_cnt >= NFREE)
                return make_grant(0, 0, 0, 0, 0, 0, 0, rafa_pkg::STAT_LIST_FULL);
            push_free(own_start[id], own_cap[id], own_slot[id]);
            own_v[id] = 1'b0;
            if (fifo_cnt < NIDS)
            begin
                fifo_ids[(fifo_head + fifo_cnt) % NIDS] = id;
                fifo_cnt++;
            end
            return make_grant(id, 0, 0, 0, 0, 1, own_slot[id], rafa_pkg::STAT_OK);
        end
        if (r.has_id)
        begin
            if (!known)
                return make_grant(0, 0, 0, 0, 0, 0, 0, rafa_pkg::STAT_UNKNOWN);
            o_st   = own_start[id];
            o_cap  = own_cap[id];
            o_slot = own_slot[id];
            if (blocks <= o_cap)
                return make_grant(id, o_st, o_cap, o_slot, 1, 0, 0, rafa_pkg::STAT_OK);
            if (fl_cnt >= NFREE)
                return make_grant(0, 0, 0, 0, 0, 0, 0, rafa_pkg::STAT_LIST_FULL);
            hit = first_fit(need, 1, o_cap);
            if (hit < 0 && !bump_fits(need))
                return make_grant(0, 0, 0, 0, 0, 0, 0, rafa_pkg::STAT_NO_SPACE);
            push_free(o_st, o_cap, o_slot);
            place_region(id, hit, need);
            return make_grant(id, own_start[id], own_cap[id], own_slot[id], 1, 1, o_slot,
                              rafa_pkg::STAT_OK);
        end
        if (fifo_cnt == 0 && id_ctr >= NIDS)
            return make_grant(0, 0, 0, 0, 0, 0, 0, rafa_pkg::STAT_NO_IDS);
        hit = first_fit(need, 0, 0);
        if (hit < 0 && !bump_fits(need))
            return make_grant(0, 0, 0, 0, 0, 0, 0, rafa_pkg::STAT_NO_SPACE);
        if (fifo_cnt > 0)
        begin
            id        = fifo_ids[fifo_head];
            fifo_head = (fifo_head + 1) % NIDS;
            fifo_cnt--;
        end
        else
        begin
            id = id_ctr;
            id_ctr++;
        end
        place_region(id, hit, need);
        own_v[id] = 1'b1;
        return make_grant(id, own_start[id], own_cap[id], own_slot[id], 1, 0, 0,
                          rafa_pkg::STAT_OK);
    endfunction

    // queue one request and its predicted grant
    task automatic send_req(logic op, logic has_id, int unsigned id, int unsigned blocks);
        rafa_pkg::req_t r;
        r.op          = op;
        r.has_id      = has_id;
        r.owner_id    = id[9:0];
        r.block_count = blocks[12:0];
        pending_reqs    = {pending_reqs, r};
        expected_grants = {expected_grants, predict_grant(r)};
    endtask

    // a live id if one turns up quickly, else the last id tried
    function automatic int unsigned pick_owner();
        int unsigned id;
        id = $urandom_range(0, NIDS - 1);
        for (int i = 0; i < 30; i++)
        begin
            id = $urandom_range(0, (id_ctr > 0) ? id_ctr - 1 : 0);
            if (own_v[id])
                return id;
        end
        return id;
    endfunction

    function automatic int unsigned pick_blocks();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 80)
            return $urandom_range(0, 31);
        if (p < 96)
            return $urandom_range(0, 255);
        return $urandom_range(0, 8191);
    endfunction

    // random well-formed traffic with some noise
    task automatic random_traffic(int n, int alloc_pct);
        int unsigned p;
        for (int k = 0; k < n; k++)
        begin
            p = $urandom_range(0, 99);
            if (p < alloc_pct)
                send_req(rafa_pkg::OP_ALLOC, 1'b0, $urandom_range(0, NIDS - 1),
                         pick_blocks());
            else if (p < alloc_pct + (100 - alloc_pct) / 2)
                send_req(rafa_pkg::OP_ALLOC, 1'b1, pick_owner(), pick_blocks());
            else if (p < 92)
                send_req(rafa_pkg::OP_FREE, $urandom_range(0, 1), pick_owner(),
                         pick_blocks());
            else
                send_req($urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, NIDS - 1), $urandom_range(0, 8191));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_grants.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_margin(int unsigned v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[3:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        margin = v;
    endtask

    // driver: request transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor: compare each response transaction with the oldest prediction
    always @(posedge clk)
    begin
        rafa_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, rsp);
                err_cnt++;
            end
            else
            begin
                e = expected_grants.pop_front();
                if (rsp.granted_id !== e.granted_id)
                    $display("%0t: granted_id exp %0d got %0d", $time, e.granted_id,
                             rsp.granted_id);
                if (rsp.region_start !== e.region_start)
                    $display("%0t: region_start exp %0d got %0d", $time, e.region_start,
                             rsp.region_start);
                if (rsp.region_capacity !== e.region_capacity)
                    $display("%0t: region_capacity exp %0d got %0d", $time,
                             e.region_capacity, rsp.region_capacity);
                if (rsp.indirect_slot !== e.indirect_slot)
                    $display("%0t: indirect_slot exp %0d got %0d", $time, e.indirect_slot,
                             rsp.indirect_slot);
                if (rsp.vertex_offset !== e.vertex_offset)
                    $display("%0t: vertex_offset exp %0d got %0d", $time, e.vertex_offset,
                             rsp.vertex_offset);
                if (rsp.index_offset !== e.index_offset)
                    $display("%0t: index_offset exp %0d got %0d", $time, e.index_offset,
                             rsp.index_offset);
                if (rsp.cleared_valid !== e.cleared_valid)
                    $display("%0t: cleared_valid exp %0d got %0d", $time, e.cleared_valid,
                             rsp.cleared_valid);
                if (rsp.cleared_slot !== e.cleared_slot)
                    $display("%0t: cleared_slot exp %0d got %0d", $time, e.cleared_slot,
                             rsp.cleared_slot);
                if (rsp.status !== e.status)
                    $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
                if (rsp !== e)
                    err_cnt++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_CAP)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 4'd0;
        hold_go       = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 62;
        margin        = rafa_pkg::MARGIN_RESET;
        id_ctr        = 0;
        fifo_head     = 0;
        fifo_cnt      = 0;
        fl_cnt        = 0;
        data_top      = 0;
        ind_top       = 0;
        for (int i = 0; i < NIDS; i++)
            own_v[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, resize, free, recycling and unknown ids
        write_margin(2);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 0, 0);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 1023, 1);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 0, 8191);
        send_req(rafa_pkg::OP_ALLOC, 1'b1, 2, 5);
        send_req(rafa_pkg::OP_ALLOC, 1'b1, 1, 1);
        send_req(rafa_pkg::OP_ALLOC, 1'b1, 1, 3);
        send_req(rafa_pkg::OP_FREE, 1'b1, 0, 8191);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 0, 1);
        send_req(rafa_pkg::OP_FREE, 1'b0, 1023, 0);
        send_req(rafa_pkg::OP_ALLOC, 1'b1, 1023, 4);
        send_req(rafa_pkg::OP_ALLOC, 1'b1, 700, 12);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 0, 8191);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 0, 8191);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 0, 8191);
        send_req(rafa_pkg::OP_FREE, 1'b0, 2, 0);
        send_req(rafa_pkg::OP_ALLOC, 1'b1, 3, 8191);
        send_req(rafa_pkg::OP_FREE, 1'b0, 1, 0);
        send_req(rafa_pkg::OP_ALLOC, 1'b0, 0, 2);
        wait_drained();

        // phase one: sender idles less than receiver
        write_margin(1);
        random_traffic(200, 45);
        wait_drained();
        write_margin(8);
        random_traffic(200, 45);
        wait_drained();

        // phase two: the other way round
        send_idle_pct = 62;
        recv_idle_pct = 37;
        write_margin(5);
        random_traffic(200, 40);
        wait_drained();
        write_margin(3);
        random_traffic(200, 40);
        wait_drained();

        // phase three: no idling, one long hold-off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_margin(1);
        hold_go <= 1'b1;
        random_traffic(230, 50);
        wait_drained();

        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== region_allocator_first_fit.f =====
sv/rafa_pkg.sv
sv/rafa_cell.sv
sv/rafa_free_list.sv
sv/region_allocator_first_fit.sv
dv/tb.sv
